[rtl/core/bta_pkg.sv]
// package for the block table allocator: sizes, codes and shared types
`timescale 1ns / 1ps

package bta_pkg;

	// pool geometry
	localparam int BLOCK_COUNT = 1024;
	localparam int BLOCK_BYTES = 32;

	// derived widths
	localparam int ADDR_W = $clog2(BLOCK_COUNT);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int SIZE_W = 16;
	localparam int NEED_W = SIZE_W + 1 - $clog2(BLOCK_BYTES);
	localparam int OFS_W  = 15;
	localparam int PCT_W  = 7;

	localparam int PCT_SCALE  = 100;
	localparam int POOL_BYTES = BLOCK_COUNT * BLOCK_BYTES;

	// request codes
	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// result codes
	typedef enum logic [1:0] {
		STS_OK         = 2'd0,
		STS_ZERO_SIZE  = 2'd1,
		STS_NO_ROOM    = 2'd2,
		STS_BAD_OFFSET = 2'd3
	} status_t;

	// control sequencer states
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_FREE_LEN,
		S_FREE,
		S_FINISH
	} state_t;

	// access to the block map: one read port, one write port
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [CNT_W-1:0]  wr_data;
	} map_req_t;

endpackage

[rtl/core/bta_map.sv]
// block map storage: one run length per block, synchronous read
`timescale 1ns / 1ps

module bta_map (
	input  logic                       clk,
	input  bta_pkg::map_req_t          req,
	output logic [bta_pkg::CNT_W-1:0]  rdata
);

	logic [bta_pkg::CNT_W-1:0] mem_q [bta_pkg::BLOCK_COUNT];
	logic [bta_pkg::CNT_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata_q <= mem_q[req.rd_addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/block_table_allocator_unit.sv]
// block table allocator top level: request sequencer, usage count and result register
`timescale 1ns / 1ps

// Allocator for a pool of 1024 blocks of 32 bytes, tracked by a map with one run
// length per block held in a single-port-read, single-port-write memory. After reset
// the map is swept clear with in_ready low. One request is handled at a time.
// Allocate walks the map from the top block down, one entry per cycle through
// the memory read port, then writes the run length into each block of the run.
// Free reads the run length, then reads and clears one entry per cycle. Clear
// sweeps all 1024 entries. Zero size, oversized, bad offset and unused requests
// go straight to the finish state. Each request gives exactly one result; the
// result register lets the next request start while the previous result waits
// for out_ready.
module block_table_allocator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   opcode,
	input  logic [bta_pkg::SIZE_W-1:0]   alloc_size,
	input  logic [bta_pkg::SIZE_W-1:0]   free_offset,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic [bta_pkg::OFS_W-1:0]    byte_offset,
	output logic [bta_pkg::PCT_W-1:0]    used_percent
);

	localparam int ADDR_W = bta_pkg::ADDR_W;
	localparam int CNT_W  = bta_pkg::CNT_W;
	localparam int NEED_W = bta_pkg::NEED_W;
	localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(bta_pkg::BLOCK_COUNT - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(bta_pkg::BLOCK_COUNT);

	bta_pkg::state_t          state_q, state_d;
	bta_pkg::map_req_t        map_req;
	logic [CNT_W-1:0]         map_rdata;

	logic [ADDR_W-1:0]        addr_q, addr_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic [CNT_W-1:0]         run_q, run_d;
	logic [CNT_W-1:0]         need_q, need_d;
	logic [CNT_W-1:0]         used_q, used_d;
	logic                     clr_op_q, clr_op_d;
	bta_pkg::status_t         sts_q, sts_d;
	logic [bta_pkg::OFS_W-1:0] ofs_q, ofs_d;

	logic                     out_valid_q, out_valid_d;
	logic [1:0]               status_q;
	logic [bta_pkg::OFS_W-1:0] byte_offset_q;
	logic [bta_pkg::PCT_W-1:0] used_percent_q;
	logic                     load_out;

	bta_pkg::op_t             op;
	logic [NEED_W-1:0]        need_full;
	logic [ADDR_W-1:0]        free_idx;
	logic [CNT_W-1:0]         run_n;
	logic [CNT_W-1:0]         room;
	logic [CNT_W-1:0]         free_len;

	bta_map u_map (
		.clk   (clk),
		.req   (map_req),
		.rdata (map_rdata)
	);

	// request decode
	assign op        = bta_pkg::op_t'(opcode);
	assign need_full = NEED_W'((32'(alloc_size) + 32'(bta_pkg::BLOCK_BYTES - 1))
		/ bta_pkg::BLOCK_BYTES);
	assign free_idx  = ADDR_W'(32'(free_offset) / bta_pkg::BLOCK_BYTES);

	// scan run and free length
	assign run_n    = (map_rdata == '0) ? run_q + CNT_W'(1) : '0;
	assign room     = FULL_CNT - CNT_W'(addr_q);
	assign free_len = (map_rdata > room) ? room : map_rdata;

	assign in_ready = (state_q == bta_pkg::S_IDLE);
	assign load_out = (state_q == bta_pkg::S_FINISH) && (!out_valid_q || out_ready);

	// next state, map access and datapath updates
	always_comb begin
		state_d  = state_q;
		addr_d   = addr_q;
		cnt_d    = cnt_q;
		run_d    = run_q;
		need_d   = need_q;
		used_d   = used_q;
		clr_op_d = clr_op_q;
		sts_d    = sts_q;
		ofs_d    = ofs_q;
		map_req  = '0;

		case (state_q)
			bta_pkg::S_CLEAR: begin
				map_req.wr_en   = 1'b1;
				map_req.wr_addr = addr_q;
				map_req.wr_data = '0;
				addr_d          = addr_q + ADDR_W'(1);
				if (addr_q == TOP_ADDR) begin
					state_d = clr_op_q ? bta_pkg::S_FINISH : bta_pkg::S_IDLE;
				end
			end

			bta_pkg::S_IDLE: begin
				if (in_valid) begin
					sts_d = bta_pkg::STS_OK;
					ofs_d = '0;
					case (op)
						bta_pkg::OP_ALLOC: begin
							if (alloc_size == '0) begin
								sts_d   = bta_pkg::STS_ZERO_SIZE;
								state_d = bta_pkg::S_FINISH;
							end else if (need_full > NEED_W'(bta_pkg::BLOCK_COUNT)) begin
								sts_d   = bta_pkg::STS_NO_ROOM;
								state_d = bta_pkg::S_FINISH;
							end else begin
								need_d          = CNT_W'(need_full);
								run_d           = '0;
								addr_d          = TOP_ADDR;
								map_req.rd_en   = 1'b1;
								map_req.rd_addr = TOP_ADDR;
								state_d         = bta_pkg::S_SCAN;
							end
						end
						bta_pkg::OP_FREE: begin
							if (32'(free_offset) >= 32'(bta_pkg::POOL_BYTES)) begin
								sts_d   = bta_pkg::STS_BAD_OFFSET;
								state_d = bta_pkg::S_FINISH;
							end else begin
								addr_d          = free_idx;
								map_req.rd_en   = 1'b1;
								map_req.rd_addr = free_idx;
								state_d         = bta_pkg::S_FREE_LEN;
							end
						end
						bta_pkg::OP_CLEAR: begin
							addr_d   = '0;
							used_d   = '0;
							clr_op_d = 1'b1;
							state_d  = bta_pkg::S_CLEAR;
						end
						default: begin
							state_d = bta_pkg::S_FINISH;
						end
					endcase
				end
			end

			// map data for addr_q is on the read port
			bta_pkg::S_SCAN: begin
				run_d = run_n;
				if (run_n == need_q) begin
					cnt_d   = need_q;
					ofs_d   = bta_pkg::OFS_W'(32'(addr_q) * bta_pkg::BLOCK_BYTES);
					state_d = bta_pkg::S_MARK;
				end else if (addr_q == '0) begin
					sts_d   = bta_pkg::STS_NO_ROOM;
					state_d = bta_pkg::S_FINISH;
				end else begin
					map_req.rd_en   = 1'b1;
					map_req.rd_addr = addr_q - ADDR_W'(1);
					addr_d          = addr_q - ADDR_W'(1);
				end
			end

			// write the run length into each block of the run, lowest first
			bta_pkg::S_MARK: begin
				map_req.wr_en   = 1'b1;
				map_req.wr_addr = addr_q;
				map_req.wr_data = need_q;
				addr_d          = addr_q + ADDR_W'(1);
				cnt_d           = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					used_d  = used_q + need_q;
					state_d = bta_pkg::S_FINISH;
				end
			end

			// run length at the freed block is on the read port
			bta_pkg::S_FREE_LEN: begin
				if (free_len == '0) begin
					state_d = bta_pkg::S_FINISH;
				end else begin
					cnt_d           = free_len;
					map_req.rd_en   = 1'b1;
					map_req.rd_addr = addr_q;
					state_d         = bta_pkg::S_FREE;
				end
			end

			// clear one entry per cycle, reading the next one ahead
			bta_pkg::S_FREE: begin
				if (map_rdata != '0) begin
					map_req.wr_en   = 1'b1;
					map_req.wr_addr = addr_q;
					map_req.wr_data = '0;
					used_d          = used_q - CNT_W'(1);
				end
				cnt_d = cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					state_d = bta_pkg::S_FINISH;
				end else begin
					map_req.rd_en   = 1'b1;
					map_req.rd_addr = addr_q + ADDR_W'(1);
					addr_d          = addr_q + ADDR_W'(1);
				end
			end

			bta_pkg::S_FINISH: begin
				clr_op_d = 1'b0;
				if (load_out) begin
					state_d = bta_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = bta_pkg::S_IDLE;
			end
		endcase
	end

	// result handshake
	always_comb begin
		out_valid_d = out_valid_q;
		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bta_pkg::S_CLEAR;
			addr_q      <= '0;
			used_q      <= '0;
			clr_op_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			addr_q      <= addr_d;
			used_q      <= used_d;
			clr_op_q    <= clr_op_d;
			out_valid_q <= out_valid_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		cnt_q  <= cnt_d;
		run_q  <= run_d;
		need_q <= need_d;
		sts_q  <= sts_d;
		ofs_q  <= ofs_d;
	end

	// result register
	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q       <= sts_q;
			byte_offset_q  <= ofs_q;
			used_percent_q <= bta_pkg::PCT_W'((32'(used_q) * bta_pkg::PCT_SCALE)
				/ bta_pkg::BLOCK_COUNT);
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign byte_offset  = byte_offset_q;
	assign used_percent = used_percent_q;

endmodule

[tb/testbench.sv]
// self-checking testbench for the block table allocator: directed and random requests
`timescale 1ns / 1ps

module testbench;
	import bta_pkg::*;

	// a run that reaches the timeout is far slower than the slowest correct run
	localparam int LIMIT_CYCLES  = 5_000_000;
	localparam int RANDOM_ITEMS  = 580;
	localparam int MAX_REPORTS   = 50;

	// one expected result transaction
	typedef struct packed {
		status_t           sts;
		logic [OFS_W-1:0]  ofs;
		logic [PCT_W-1:0]  pct;
	} alloc_result_t;

	// block map predictor and expected result store
	class pool_scoreboard;
		logic [CNT_W-1:0] run_len_map [BLOCK_COUNT];
		int unsigned      used_count;
		alloc_result_t    pending_results [$];
		int               live_offsets [$];
		int unsigned      error_count;

		function new();
			foreach (run_len_map[i])
				run_len_map[i] = '0;
			used_count  = 0;
			error_count = 0;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		// work out the result of an accepted request and update the map
		function void note_request(op_t op, logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] ofs);
			alloc_result_t r;
			int need;
			int run;
			int blk;
			int idx;
			int len;
			int found;
			r.sts = STS_OK;
			r.ofs = '0;
			case (op)
			OP_ALLOC: begin
				if (size == 0) begin
					r.sts = STS_ZERO_SIZE;
				end else begin
					need  = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
					run   = 0;
					found = 0;
					// walk down from the top block looking for a free run
					for (blk = BLOCK_COUNT - 1; blk >= 0 && found == 0; blk--) begin
						if (run_len_map[blk] == 0)
							run++;
						else
							run = 0;
						if (run == need) begin
							for (int j = 0; j < need; j++)
								run_len_map[blk + j] = CNT_W'(need);
							used_count += need;
							r.ofs = OFS_W'(blk * BLOCK_BYTES);
							live_offsets.push_back(blk * BLOCK_BYTES);
							found = 1;
						end
					end
					if (found == 0)
						r.sts = STS_NO_ROOM;
				end
			end
			OP_FREE: begin
				if (int'(ofs) >= POOL_BYTES) begin
					r.sts = STS_BAD_OFFSET;
				end else begin
					idx = int'(ofs) / BLOCK_BYTES;
					len = int'(run_len_map[idx]);
					// stored length is trusted but clamped at the top of the map
					if (len > BLOCK_COUNT - idx)
						len = BLOCK_COUNT - idx;
					for (int j = 0; j < len; j++) begin
						if (run_len_map[idx + j] != 0) begin
							run_len_map[idx + j] = '0;
							used_count--;
						end
					end
					for (int k = 0; k < live_offsets.size(); k++) begin
						if (live_offsets[k] == idx * BLOCK_BYTES) begin
							live_offsets.delete(k);
							break;
						end
					end
				end
			end
			OP_CLEAR: begin
				foreach (run_len_map[i])
					run_len_map[i] = '0;
				used_count = 0;
				live_offsets.delete();
			end
			default: ;
			endcase
			r.pct = PCT_W'(used_count * PCT_SCALE / BLOCK_COUNT);
			pending_results.push_back(r);
		endfunction

		// compare a result transaction with the oldest expectation
		function void check_result(logic [1:0] sts, logic [OFS_W-1:0] ofs, logic [PCT_W-1:0] pct);
			alloc_result_t e;
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected result status %0d offset %0d percent %0d",
						$time, sts, ofs, pct);
				return;
			end
			e = pending_results.pop_front();
			if (sts != e.sts) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: status expected %0d actual %0d", $time, e.sts, sts);
			end
			if (ofs != e.ofs) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: byte_offset expected %0d actual %0d", $time, e.ofs, ofs);
			end
			if (pct != e.pct) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: used_percent expected %0d actual %0d", $time, e.pct, pct);
			end
		endfunction
	endclass

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [1:0]        opcode      = '0;
	logic [SIZE_W-1:0] alloc_size  = '0;
	logic [SIZE_W-1:0] free_offset = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic [1:0]        status;
	logic [OFS_W-1:0]  byte_offset;
	logic [PCT_W-1:0]  used_percent;

	pool_scoreboard sb = new();
	int             burst_left = 0;
	int unsigned    rx_cycle   = 0;
	int             stall_left = 0;
	int unsigned    cycles     = 0;

	block_table_allocator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.alloc_size   (alloc_size),
		.free_offset  (free_offset),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.byte_offset  (byte_offset),
		.used_percent (used_percent)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// hold one request until it is accepted, then predict its result
	task automatic send_request(op_t op, logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] ofs);
		in_valid    <= 1'b1;
		opcode      <= op;
		alloc_size  <= size;
		free_offset <= ofs;
		do @(posedge clk); while (!in_ready);
		sb.note_request(op, size, ofs);
	endtask

	// bursts of back-to-back requests separated by idle gaps
	task automatic pace_sender();
		int pick;
		if (burst_left == 0) begin
			pick = $urandom_range(0, 99);
			in_valid <= 1'b0;
			if (pick < 70)
				repeat ($urandom_range(1, 6)) @(posedge clk);
			else if (pick < 95)
				repeat ($urandom_range(7, 60)) @(posedge clk);
			else
				repeat ($urandom_range(61, 400)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 16);
		end
		burst_left--;
	endtask

	// stop sending until every outstanding result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// one random request, mostly allocations of small runs and frees of live runs
	task automatic send_random();
		int pick;
		int sub;
		int base;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] ofs;
		pick = $urandom_range(0, 99);
		sub  = $urandom_range(0, 99);
		size = SIZE_W'($urandom);
		ofs  = SIZE_W'($urandom);
		if (pick < 52) begin
			if (sub < 3)
				size = '0;
			else if (sub < 70)
				size = SIZE_W'($urandom_range(1, 128));
			else if (sub < 88)
				size = SIZE_W'($urandom_range(129, 1024));
			else if (sub < 95)
				size = SIZE_W'($urandom_range(1025, 8192));
			else if (sub < 98)
				size = SIZE_W'($urandom_range(8193, POOL_BYTES));
			send_request(OP_ALLOC, size, ofs);
		end else if (pick < 88) begin
			if (sb.live_offsets.size() != 0 && sub < 82) begin
				base = sb.live_offsets[$urandom_range(0, sb.live_offsets.size() - 1)];
				// start of a live run, or one to three blocks above its start
				if (sub < 65)
					ofs = SIZE_W'(base + $urandom_range(0, BLOCK_BYTES - 1));
				else
					ofs = SIZE_W'((base + BLOCK_BYTES * $urandom_range(1, 3)) % POOL_BYTES);
			end else if (sub < 92) begin
				ofs = SIZE_W'($urandom_range(0, POOL_BYTES - 1));
			end else begin
				ofs = SIZE_W'($urandom_range(POOL_BYTES, 65535));
			end
			send_request(OP_FREE, size, ofs);
		end else if (pick < 91) begin
			send_request(OP_CLEAR, size, ofs);
		end else begin
			send_request(OP_NONE, size, ofs);
		end
	endtask

	// receiver backpressure: four modes in rotation
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle / 1500) % 4)
		0: out_ready <= 1'b1;
		1: out_ready <= ($urandom_range(0, 1) == 1);
		2: out_ready <= (rx_cycle[1:0] == 2'b00);
		default: begin
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready  <= 1'b0;
			end else begin
				out_ready  <= 1'b1;
				stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
			end
		end
		endcase
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, byte_offset, used_percent);
	end

	// timeout
	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("block_table_allocator_unit: mismatch");
		$finish;
	end

	// stimulus
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: errors, clamped free at the top, full pool, frees inside runs
		send_request(OP_ALLOC, 16'd0, 16'hffff);
		send_request(OP_ALLOC, 16'hffff, 16'd0);
		send_request(OP_ALLOC, 16'd160, 16'd0);
		send_request(OP_FREE, 16'hffff, 16'd32704);
		send_request(OP_FREE, 16'd0, 16'd32768);
		send_request(OP_FREE, 16'd0, 16'hffff);
		pace_sender();
		send_request(OP_FREE, 16'd5, 16'd0);
		send_request(OP_ALLOC, 16'd32768, 16'd0);
		send_request(OP_CLEAR, 16'hffff, 16'hffff);
		send_request(OP_ALLOC, 16'd32768, 16'd0);
		send_request(OP_ALLOC, 16'd1, 16'd0);
		pace_sender();
		send_request(OP_FREE, 16'd0, 16'd31);
		send_request(OP_ALLOC, 16'd1, 16'd0);
		send_request(OP_ALLOC, 16'd32, 16'd0);
		send_request(OP_ALLOC, 16'd33, 16'd0);
		send_request(OP_FREE, 16'd0, 16'd32736);
		send_request(OP_ALLOC, 16'd64, 16'd0);
		pace_sender();
		send_request(OP_FREE, 16'd0, 16'd32672);
		send_request(OP_NONE, 16'haaaa, 16'h5555);
		send_request(OP_ALLOC, 16'd32767, 16'd0);
		send_request(OP_ALLOC, 16'd31, 16'hffff);
		send_request(OP_CLEAR, 16'd0, 16'd0);
		send_request(OP_NONE, 16'h5555, 16'haaaa);
		drain_results();

		// random traffic, with a full drain halfway through
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2)
				drain_results();
			pace_sender();
			send_random();
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (sb.error_count == 0 && sb.pending() == 0)
			$display("block_table_allocator_unit: match");
		else
			$display("block_table_allocator_unit: mismatch");
		$finish;
	end

endmodule
